@@ design/kscl_pkg.sv @@
package kscl_pkg;

  localparam int KwCount    = 37;
  localparam int KwKeyBytes = 10;
  localparam int KwWordMax  = 12;
  localparam int SlotCount  = 4;

  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_UNDER   = 8'h5f;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_LONG    = 3'd2,
    MODE_LITERAL = 3'd3,
    MODE_LINE    = 3'd4,
    MODE_BLOCK   = 3'd5
  } lex_mode_e;

  // One request worth of output: loose bytes in slots, with an optional
  // identifier flush spliced in after the first split slots.
  typedef struct packed {
    logic [SlotCount-1:0][7:0] slot;
    logic [2:0]                ne;
    logic [2:0]                split;
    logic                      has_id;
    logic                      hit;
    logic [5:0]                kw;
    logic [4:0]                nid;
    logic                      last;
  } job_t;

  // Keys and words are right-justified string constants.
  localparam logic [8*KwKeyBytes-1:0] KW_KEY [KwCount] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
    "unsigned", "void", "volatile", "while", "_Bool", "_Complex", "_Imaginary"
  };

  localparam logic [3:0] KW_KLEN [KwCount] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4, 4'd4, 4'd6,
    4'd5, 4'd3, 4'd4, 4'd2, 4'd6, 4'd3, 4'd4, 4'd8, 4'd8, 4'd6, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5, 4'd5, 4'd8,
    4'd10
  };

  localparam logic [8*KwWordMax-1:0] KW_WORD [KwCount] = '{
    "autom\303\241tico", "romper", "caso", "car\303\241cter", "constante",
    "continuar", "por\137defecto", "hacer", "doble", "sino",
    "enumeraci\303\263n", "externo", "flotante", "para", "ir_a", "si",
    "en\137linea", "entero", "largo", "registro", "restringido", "retornar",
    "corto", "con\137signo", "tamano", "estatico", "estructura", "segun", "tipo",
    "union", "sin\137signo", "vacio", "volatile", "mientras", "booleano",
    "complejo", "imaginario"
  };

  localparam logic [3:0] KW_WLEN [KwCount] = '{
    4'd11, 4'd6, 4'd4, 4'd9, 4'd9, 4'd9, 4'd11, 4'd5, 4'd5, 4'd4, 4'd12, 4'd7,
    4'd8, 4'd4, 4'd4, 4'd2, 4'd8, 4'd6, 4'd5, 4'd8, 4'd11, 4'd8, 4'd5, 4'd9,
    4'd6, 4'd8, 4'd10, 4'd5, 4'd4, 4'd5, 4'd9, 4'd5, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd10
  };

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) || c == CH_UNDER;
  endfunction

  function automatic logic is_body(logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  // Returns {hit, index}; b[i] is identifier byte i.
  function automatic logic [6:0] kw_lookup(logic [KwKeyBytes-1:0][7:0] b,
                                           logic [4:0] len);
    logic [6:0] res;
    logic       ok;
    res = '0;
    for (int k = 0; k < KwCount; k++) begin
      ok = (len == {1'b0, KW_KLEN[k]});
      for (int i = 0; i < KwKeyBytes; i++) begin
        if (i < int'(KW_KLEN[k]) &&
            b[i] != KW_KEY[k][8*(int'(KW_KLEN[k])-1-i) +: 8]) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        res = {1'b1, 6'(k)};
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] kw_word_byte(logic [5:0] kw, logic [3:0] j);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < KwCount; k++) begin
      if (kw == 6'(k)) begin
        r = KW_WORD[k][8*(int'(KW_WLEN[k]) - 1 - int'(j)) +: 8];
      end
    end
    return r;
  endfunction

endpackage

@@ design/kscl_if.sv @@
interface kscl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;
  modport source (output valid, in_byte, text_last, input ready);
  modport sink (input valid, in_byte, text_last, output ready);
endinterface

interface kscl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       text_end;
  modport source (output valid, out_byte, run_end, text_end, input ready);
  modport sink (input valid, out_byte, run_end, text_end, output ready);
endinterface

@@ design/keyword_substituting_c_lexer.sv @@
// C source in, translated C source out, one byte per request on each side.
// String and char literals (with backslash escapes), line comments and block
// comments pass through unchanged; outside them identifiers are gathered in an
// IDENT_BUFFER_LEN byte buffer and, once complete, a C keyword among the 37 is
// replaced by its Spanish word in UTF-8 while anything else is copied. A '/'
// is held until the next byte shows whether it opens a comment. Raise
// text_last on the final byte: pending identifier and slash are flushed,
// text_end marks the last output byte, and the lexer starts a new text.
// run_end marks the last output byte caused by each input byte; an input byte
// that causes no output (identifier letters, a held slash) gives none.
// Rate: the front lexer takes one input byte per cycle into a two-entry run
// queue while it is not full; the back end emits one output byte per cycle
// while the output is not stalled. An input byte produces usually one byte,
// none for a byte that only fills the identifier buffer, up to 13 for a
// 12-byte keyword word followed by one loose byte, IDENT_BUFFER_LEN + 1 for
// an overlong identifier. The single output byte port bounds throughput.
module keyword_substituting_c_lexer
  import kscl_pkg::*;
#(
  parameter int IDENT_BUFFER_LEN = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kscl_in_if.sink     in_i,
  kscl_out_if.source  out_o
);

  localparam int JobW = $bits(job_t);
  localparam int BufW = 8 * IDENT_BUFFER_LEN;

  // Front to queue
  logic                             push, full;
  job_t                             f_job;
  logic [IDENT_BUFFER_LEN-1:0][7:0] f_buf;

  // Queue to back
  logic                             q_valid, pop;
  logic [JobW+BufW-1:0]             q_data;
  job_t                             b_job;
  logic [IDENT_BUFFER_LEN-1:0][7:0] b_buf;

  kscl_front #(.IDENT_BUFFER_LEN(IDENT_BUFFER_LEN)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (f_job),
    .buf_o  (f_buf)
  );

  // Hold finished runs so lexing and byte emission stall independently.
  kscl_fifo #(.W(JobW + BufW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_job, f_buf}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign b_job = q_data[JobW+BufW-1:BufW];
  assign b_buf = q_data[BufW-1:0];

  kscl_back #(.IDENT_BUFFER_LEN(IDENT_BUFFER_LEN)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (b_job),
    .buf_i   (b_buf),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ design/kscl_front.sv @@
module kscl_front
  import kscl_pkg::*;
#(
  parameter int IDENT_BUFFER_LEN = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  kscl_in_if.sink                         in_i,
  input  logic                            full_i,
  output logic                            push_o,
  output job_t                            job_o,
  output logic [IDENT_BUFFER_LEN-1:0][7:0] buf_o
);

  localparam int LenW = $clog2(IDENT_BUFFER_LEN + 1);
  localparam int IdxW = $clog2(IDENT_BUFFER_LEN);

  lex_mode_e                          mode_q, mode_d;
  logic                               qs_q, qs_d, esc_q, esc_d;
  logic                               star_q, star_d, slash_q, slash_d;
  logic [LenW-1:0]                    len_q, len_d;
  logic [IDENT_BUFFER_LEN-1:0][7:0]   buf_q, buf_d;

  logic [SlotCount-1:0][7:0]          e_v;
  logic [2:0]                         ne_v, fl_at;
  logic                               fl, fl_raw, do_norm, do_plain, accept;
  logic [IDENT_BUFFER_LEN-1:0][7:0]   fl_buf;
  logic [LenW-1:0]                    fl_len;
  logic [KwKeyBytes-1:0][7:0]         key_b;
  logic [6:0]                         look;
  logic                               hit;
  logic [4:0]                         nid;
  logic [5:0]                         total;
  logic [7:0]                         c;

  assign c      = in_i.in_byte;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;

  always_comb begin
    mode_d = mode_q; qs_d = qs_q; esc_d = esc_q; star_d = star_q;
    slash_d = slash_q; len_d = len_q; buf_d = buf_q;
    e_v = '0; ne_v = '0; fl = 1'b0; fl_raw = 1'b0; fl_at = '0;
    fl_buf = buf_q; fl_len = len_q; do_norm = 1'b0; do_plain = 1'b0;
    unique case (mode_q)
      MODE_LITERAL: begin
        e_v[ne_v[1:0]] = c; ne_v = ne_v + 3'd1;
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (c == CH_BSLASH) begin
          esc_d = 1'b1;
        end else if (c == (qs_q ? CH_SQUOTE : CH_DQUOTE)) begin
          mode_d = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (c == CH_NEWLINE) begin
          mode_d = MODE_NORMAL;
        end
        e_v[ne_v[1:0]] = c; ne_v = ne_v + 3'd1;
      end
      MODE_BLOCK: begin
        e_v[ne_v[1:0]] = c; ne_v = ne_v + 3'd1;
        if (star_q && c == CH_SLASH) begin
          mode_d = MODE_NORMAL;
          star_d = 1'b0;
        end else begin
          star_d = (c == CH_STAR);
        end
      end
      MODE_LONG: begin
        if (is_body(c)) begin
          e_v[ne_v[1:0]] = c; ne_v = ne_v + 3'd1;
        end else begin
          do_norm = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_body(c)) begin
          if (len_q < LenW'(IDENT_BUFFER_LEN)) begin
            buf_d[len_q[IdxW-1:0]] = c;
            len_d = len_q + LenW'(1);
          end else begin
            // Overlong: dump the buffer untranslated, then the byte.
            fl = 1'b1; fl_raw = 1'b1; fl_at = ne_v;
            e_v[ne_v[1:0]] = c; ne_v = ne_v + 3'd1;
            len_d = '0;
            mode_d = MODE_LONG;
          end
        end else begin
          fl = 1'b1; fl_at = ne_v;
          len_d = '0;
          do_norm = 1'b1;
        end
      end
      default: do_norm = 1'b1;
    endcase

    if (do_norm) begin
      mode_d = MODE_NORMAL;
      if (slash_d) begin
        slash_d = 1'b0;
        e_v[ne_v[1:0]] = CH_SLASH; ne_v = ne_v + 3'd1;
        if (c == CH_SLASH) begin
          e_v[ne_v[1:0]] = CH_SLASH; ne_v = ne_v + 3'd1;
          mode_d = MODE_LINE;
        end else if (c == CH_STAR) begin
          e_v[ne_v[1:0]] = CH_STAR; ne_v = ne_v + 3'd1;
          mode_d = MODE_BLOCK;
          star_d = 1'b0;
        end else begin
          do_plain = 1'b1;
        end
      end else begin
        do_plain = 1'b1;
      end
    end

    if (do_plain) begin
      if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        e_v[ne_v[1:0]] = c; ne_v = ne_v + 3'd1;
        mode_d = MODE_LITERAL;
        qs_d = (c == CH_SQUOTE);
        esc_d = 1'b0;
      end else if (c == CH_SLASH) begin
        slash_d = 1'b1;
      end else if (is_letter(c)) begin
        buf_d[0] = c;
        len_d = LenW'(1);
        mode_d = MODE_IDENT;
      end else begin
        e_v[ne_v[1:0]] = c; ne_v = ne_v + 3'd1;
      end
    end

    if (in_i.text_last) begin
      if (mode_d == MODE_IDENT) begin
        fl = 1'b1; fl_raw = 1'b0; fl_at = ne_v;
        fl_buf = buf_d; fl_len = len_d;
      end
      if (slash_d) begin
        e_v[ne_v[1:0]] = CH_SLASH; ne_v = ne_v + 3'd1;
      end
      mode_d = MODE_NORMAL; qs_d = 1'b0; esc_d = 1'b0; star_d = 1'b0;
      slash_d = 1'b0; len_d = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < KwKeyBytes; i++) begin
      key_b[i] = fl_buf[i];
    end
  end

  assign look  = kw_lookup(key_b, 5'(fl_len));
  assign hit   = look[6] && !fl_raw;
  assign nid   = hit ? {1'b0, KW_WLEN[look[5:0]]} : 5'(fl_len);
  assign total = 6'(ne_v) + (fl ? 6'(nid) : 6'd0);

  assign push_o = accept && total != 6'd0;
  always_comb begin
    job_o.slot   = e_v;
    job_o.ne     = ne_v;
    job_o.split  = fl ? fl_at : ne_v;
    job_o.has_id = fl;
    job_o.hit    = hit;
    job_o.kw     = look[5:0];
    job_o.nid    = nid;
    job_o.last   = in_i.text_last;
  end
  assign buf_o = fl_buf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL; qs_q <= 1'b0; esc_q <= 1'b0;
      star_q <= 1'b0; slash_q <= 1'b0; len_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d; qs_q <= qs_d; esc_q <= esc_d;
      star_q <= star_d; slash_q <= slash_d; len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= buf_d;
    end
  end

endmodule

@@ design/kscl_fifo.sv @@
module kscl_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [1:0][W-1:0] mem_q;
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != 2'd0)) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

@@ design/kscl_back.sv @@
module kscl_back
  import kscl_pkg::*;
#(
  parameter int IDENT_BUFFER_LEN = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  job_t                             job_i,
  input  logic [IDENT_BUFFER_LEN-1:0][7:0] buf_i,
  output logic                             pop_o,
  kscl_out_if.source                       out_o
);

  localparam int IdxW = $clog2(IDENT_BUFFER_LEN);
  localparam int PosW = $clog2(KwWordMax + IDENT_BUFFER_LEN + SlotCount + 1);

  job_t                             job_q;
  logic [IDENT_BUFFER_LEN-1:0][7:0] buf_q;
  logic                             cur_q;
  logic [PosW-1:0]                  pos_q, total, nid_eff, k, post;
  logic                             out_valid_q, out_run_q, out_text_q;
  logic [7:0]                       out_byte_q, byte_v;
  logic                             free, emit, final_byte, load;

  assign nid_eff    = job_q.has_id ? PosW'(job_q.nid) : '0;
  assign total      = PosW'(job_q.ne) + nid_eff;
  assign k          = pos_q - PosW'(job_q.split);
  assign post       = pos_q - nid_eff;
  assign free       = !out_valid_q || out_o.ready;
  assign emit       = cur_q && free;
  assign final_byte = emit && (pos_q == total - PosW'(1));
  assign load       = !cur_q || final_byte;
  assign pop_o      = load && valid_i;

  always_comb begin
    if (pos_q < PosW'(job_q.split)) begin
      byte_v = job_q.slot[pos_q[1:0]];
    end else if (job_q.has_id && pos_q < PosW'(job_q.split) + nid_eff) begin
      byte_v = job_q.hit ? kw_word_byte(job_q.kw, k[3:0]) : buf_q[k[IdxW-1:0]];
    end else begin
      byte_v = job_q.slot[post[1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 1'b0; pos_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        cur_q <= valid_i;
        pos_q <= '0;
      end else if (emit) begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      buf_q <= buf_i;
    end
    if (emit) begin
      out_byte_q <= byte_v;
      out_run_q  <= final_byte;
      out_text_q <= final_byte && job_q.last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.run_end  = out_run_q;
  assign out_o.text_end = out_text_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q |-> pos_q < total) else $error("byte position past end of run");
  a_text_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_text_q |-> out_run_q) else $error("text end without run end");
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q |-> total != '0) else $error("empty run loaded");

endmodule
